// ----- rtl/fsrv_pkg.sv -----
// Shared types and constants for the fixed-step resampler with volume.
// Used by fsrv_scale, fsrv_phase, fixed_step_resampler_volume and the checker.
package fsrv_pkg;

  // Field and register widths.
  localparam int SAMPLE_W   = 16;
  localparam int OUT_W      = 19;
  localparam int STEP_W     = 21;
  localparam int VOL_W      = 12;
  localparam int PAN_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // Phase accumulator and repeat cap.
  localparam int FRAC_WIDTH = 16;
  localparam int MAX_REPEAT = 16;
  localparam int CNT_W      = $clog2(MAX_REPEAT);
  localparam int SUM_W      = (STEP_W > FRAC_WIDTH) ? STEP_W + 1 : FRAC_WIDTH + 1;
  localparam int ADV_W      = SUM_W - FRAC_WIDTH;
  localparam int SKIP_W     = 5;
  localparam int SKIP_MAX   = 31;

  // Scaling: signed sample times unsigned volume, 16-bit mode shift.
  localparam int PROD_W     = SAMPLE_W + VOL_W + 1;
  localparam int VOL_SHIFT  = 8;
  localparam int BYTE_W     = 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE  = 3'd4;

  // Pan codes; the unused code routes to both sides.
  localparam logic [PAN_W-1:0] PAN_LEFT  = 2'd0;
  localparam logic [PAN_W-1:0] PAN_RIGHT = 2'd1;
  localparam logic [PAN_W-1:0] PAN_BOTH  = 2'd2;

  // Register reset values.
  localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;
  localparam logic [VOL_W-1:0]  VOL_RESET  = 12'd256;

  // Commands from the sequencer to the phase unit.
  typedef struct packed {
    logic start;     // a new run begins
    logic skip_dec;  // an input word is dropped
    logic advance;   // one output word was taken
  } fsrv_ctrl_t;

  // Status from the phase unit.
  typedef struct packed {
    logic skip_nz;   // input words are still to be dropped
    logic last;      // the current output word ends the run
  } fsrv_stat_t;

endpackage

// ----- rtl/fixed_step_resampler_volume.sv -----
// Top level of the fixed-step sample-and-hold resampler with volume.
// Depends on fsrv_pkg, fsrv_scale and fsrv_phase.
//
//  port group  direction  handshake           payload
//  in_         input      in_valid/in_stall   in_sample
//  out_        output     out_valid/out_stall out_left_sample, out_right_sample,
//                                             out_last_of_run
//  cfg_        input      cfg_we              cfg_index, cfg_data
//
// An input word that is dropped by the skip counter is taken in the idle state.
// Otherwise the shared volume unit scales the left side and then the right side,
// then the run of N output words (1 to 16) goes out at one word per cycle while
// the output side does not stall.
// Reset is synchronous and active low; it restores the configuration register defaults.
// A stall on the output holds the current word; the input is stalled until
// the last word of the run has been taken.
module fixed_step_resampler_volume (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [fsrv_pkg::SAMPLE_W-1:0] in_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [fsrv_pkg::OUT_W-1:0]  out_left_sample,
  output logic signed [fsrv_pkg::OUT_W-1:0]  out_right_sample,
  output logic                               out_last_of_run,
  input  logic                               cfg_we,
  input  logic [fsrv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fsrv_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_L = 3'd1;
  localparam logic [2:0] ST_MUL_R = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]                         state_r, state_nxt;
  logic [fsrv_pkg::STEP_W-1:0]        step_r;
  logic [fsrv_pkg::VOL_W-1:0]         left_r;
  logic [fsrv_pkg::VOL_W-1:0]         right_r;
  logic [fsrv_pkg::PAN_W-1:0]         pan_r;
  logic                               byte_r;
  logic signed [fsrv_pkg::SAMPLE_W-1:0] sample_r;
  logic [fsrv_pkg::OUT_W-1:0]         lval_r;
  logic [fsrv_pkg::OUT_W-1:0]         rval_r;
  logic [fsrv_pkg::OUT_W-1:0]         scaled;
  logic [fsrv_pkg::VOL_W-1:0]         vol_sel;
  logic                               to_left;
  logic                               to_right;
  logic                               in_acc;
  logic                               out_acc;
  fsrv_pkg::fsrv_ctrl_t               ctrl;
  fsrv_pkg::fsrv_stat_t               stat;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= fsrv_pkg::STEP_RESET;
      left_r  <= fsrv_pkg::VOL_RESET;
      right_r <= fsrv_pkg::VOL_RESET;
      pan_r   <= fsrv_pkg::PAN_LEFT;
      byte_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fsrv_pkg::CFG_STEP:  step_r  <= cfg_data[fsrv_pkg::STEP_W-1:0];
        fsrv_pkg::CFG_LEFT:  left_r  <= cfg_data[fsrv_pkg::VOL_W-1:0];
        fsrv_pkg::CFG_RIGHT: right_r <= cfg_data[fsrv_pkg::VOL_W-1:0];
        fsrv_pkg::CFG_PAN:   pan_r   <= cfg_data[fsrv_pkg::PAN_W-1:0];
        fsrv_pkg::CFG_BYTE:  byte_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshakes.
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // Pan routing; an unrouted side gets a zero volume word.
  assign to_left  = (pan_r != fsrv_pkg::PAN_RIGHT);
  assign to_right = (pan_r != fsrv_pkg::PAN_LEFT);

  always_comb begin
    if (state_r == ST_MUL_L) begin
      vol_sel = to_left ? left_r : '0;
    end else begin
      vol_sel = to_right ? right_r : '0;
    end
  end

  fsrv_scale u_scale (
    .clk       (clk),
    .sample    (sample_r),
    .vol       (vol_sel),
    .byte_mode (byte_r),
    .result    (scaled)
  );

  // Commands to the phase unit.
  assign ctrl.start    = in_acc && !stat.skip_nz;
  assign ctrl.skip_dec = in_acc && stat.skip_nz;
  assign ctrl.advance  = out_acc;

  fsrv_phase u_phase (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step_r),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (ctrl.start) begin
          state_nxt = ST_MUL_L;
        end
      end
      ST_MUL_L: state_nxt = ST_MUL_R;
      ST_MUL_R: state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_acc && stat.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sample latch and scaled results of both sides.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      if (byte_r) begin
        sample_r <= {{(fsrv_pkg::SAMPLE_W-fsrv_pkg::BYTE_W){in_sample[fsrv_pkg::BYTE_W-1]}},
                     in_sample[fsrv_pkg::BYTE_W-1:0]};
      end else begin
        sample_r <= in_sample;
      end
    end
    if (state_r == ST_MUL_R) begin
      lval_r <= scaled;
    end
    if (state_r == ST_LOAD) begin
      rval_r <= scaled;
    end
  end

  assign out_left_sample  = lval_r;
  assign out_right_sample = rval_r;
  assign out_last_of_run  = stat.last;

endmodule

// ----- rtl/fsrv_scale.sv -----
// Shared volume unit: one signed multiply, optional shift and saturation.
// Depends on fsrv_pkg.
module fsrv_scale (
  input  logic                             clk,
  input  logic signed [fsrv_pkg::SAMPLE_W-1:0] sample,
  input  logic [fsrv_pkg::VOL_W-1:0]       vol,
  input  logic                             byte_mode,
  output logic [fsrv_pkg::OUT_W-1:0]       result
);

  logic signed [fsrv_pkg::PROD_W-1:0]                 prod;
  logic signed [fsrv_pkg::PROD_W-1:0]                 shifted;
  logic [fsrv_pkg::PROD_W-fsrv_pkg::OUT_W:0]          hi_bits;
  logic                                               fits;
  logic [fsrv_pkg::OUT_W-1:0]                         res_nxt;
  logic [fsrv_pkg::OUT_W-1:0]                         res_r;

  // Product of the sample and the zero-extended volume word.
  assign prod = fsrv_pkg::PROD_W'(sample) * $signed({1'b0, vol});

  // 16-bit mode floors the product divided by 256; byte mode keeps it.
  assign shifted = byte_mode ? prod : (prod >>> fsrv_pkg::VOL_SHIFT);

  // Saturate to the output range when the upper bits are not a sign run.
  assign hi_bits = shifted[fsrv_pkg::PROD_W-1:fsrv_pkg::OUT_W-1];
  assign fits    = (hi_bits == '0) || (hi_bits == '1);

  always_comb begin
    if (fits) begin
      res_nxt = shifted[fsrv_pkg::OUT_W-1:0];
    end else if (shifted[fsrv_pkg::PROD_W-1]) begin
      res_nxt = {1'b1, {(fsrv_pkg::OUT_W-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(fsrv_pkg::OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign result = res_r;

endmodule

// ----- rtl/fsrv_phase.sv -----
// Phase accumulator, repeat counter and skip counter of the resampler.
// Depends on fsrv_pkg.
module fsrv_phase (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [fsrv_pkg::STEP_W-1:0]    step,
  input  fsrv_pkg::fsrv_ctrl_t           ctrl,
  output fsrv_pkg::fsrv_stat_t           stat
);

  logic [fsrv_pkg::FRAC_WIDTH-1:0] frac_r, frac_nxt;
  logic [fsrv_pkg::SKIP_W-1:0]     skip_r, skip_nxt;
  logic [fsrv_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [fsrv_pkg::SUM_W-1:0]      sum;
  logic [fsrv_pkg::ADV_W-1:0]      adv;
  logic [fsrv_pkg::ADV_W-1:0]      adv_m1;
  logic                            carry;
  logic                            last;

  // Phase after the current output word.
  assign sum    = fsrv_pkg::SUM_W'(frac_r) + fsrv_pkg::SUM_W'(step);
  assign adv    = sum[fsrv_pkg::SUM_W-1:fsrv_pkg::FRAC_WIDTH];
  assign adv_m1 = adv - fsrv_pkg::ADV_W'(1);
  assign carry  = (adv != '0);
  assign last   = carry || (cnt_r == fsrv_pkg::CNT_W'(fsrv_pkg::MAX_REPEAT - 1));

  // Next state of the counters and the fraction.
  always_comb begin
    frac_nxt = frac_r;
    skip_nxt = skip_r;
    cnt_nxt  = cnt_r;
    if (ctrl.start) begin
      cnt_nxt = '0;
    end
    if (ctrl.skip_dec) begin
      skip_nxt = skip_r - fsrv_pkg::SKIP_W'(1);
    end
    if (ctrl.advance) begin
      frac_nxt = sum[fsrv_pkg::FRAC_WIDTH-1:0];
      cnt_nxt  = cnt_r + fsrv_pkg::CNT_W'(1);
      if (carry) begin
        if (adv_m1 > fsrv_pkg::ADV_W'(fsrv_pkg::SKIP_MAX)) begin
          skip_nxt = fsrv_pkg::SKIP_W'(fsrv_pkg::SKIP_MAX);
        end else begin
          skip_nxt = fsrv_pkg::SKIP_W'(adv_m1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= '0;
      skip_r <= '0;
      cnt_r  <= '0;
    end else begin
      frac_r <= frac_nxt;
      skip_r <= skip_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign stat.skip_nz = (skip_r != '0);
  assign stat.last    = last;

endmodule

// ----- rtl/fsrv_checker.sv -----
// Port-level checks for the resampler, bound to its top level.
// Depends on fixed_step_resampler_volume and fsrv_pkg.
module fsrv_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [fsrv_pkg::OUT_W-1:0]        out_left_sample,
  input logic [fsrv_pkg::OUT_W-1:0]        out_right_sample,
  input logic                              out_last_of_run
);

  // One word at a time: no input word is taken while a result is shown.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !out_valid)
    else $error("input word taken while an output word is pending");

  // The volume unit needs cycles before the first output word.
  a_scale_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("output word appeared right after an input word");

  // The run ends with the word marked last.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_of_run) |=> !out_valid)
    else $error("output continued after the last word of a run");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_left_sample)
      && $stable(out_right_sample) && $stable(out_last_of_run)))
    else $error("stalled output word changed");

endmodule

bind fixed_step_resampler_volume fsrv_checker u_fsrv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_left_sample  (out_left_sample),
  .out_right_sample (out_right_sample),
  .out_last_of_run  (out_last_of_run)
);

// ----- tb/tb_fixed_step_resampler_volume.sv -----
// Self-checking testbench for fixed_step_resampler_volume: directed and random
// sample words are checked against an in-bench model of the resampler.
// Depends on fsrv_pkg and the RTL of fixed_step_resampler_volume.
module tb_fixed_step_resampler_volume;

  localparam logic [fsrv_pkg::PAN_W-1:0] PAN_SPARE = 2'd3;
  localparam logic [fsrv_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO =
    fsrv_pkg::CFG_IDX_W'(fsrv_pkg::CFG_BYTE + 1);
  localparam logic [fsrv_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = '1;
  localparam logic [fsrv_pkg::STEP_W-1:0] STEP_MIN = 21'd4096;
  localparam logic [fsrv_pkg::STEP_W-1:0] STEP_MAX = 21'd1048576;
  localparam logic [fsrv_pkg::VOL_W-1:0] VOL_MAX = 12'd2048;
  localparam longint OUT_LO = -(longint'(1) << (fsrv_pkg::OUT_W - 1));
  localparam longint OUT_HI = (longint'(1) << (fsrv_pkg::OUT_W - 1)) - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [fsrv_pkg::OUT_W-1:0] left;
    logic signed [fsrv_pkg::OUT_W-1:0] right;
    logic last;
  } mix_word_t;

  // Model of the resampler: register copies, phase state and the words still owed.
  class resample_scoreboard;
    logic [fsrv_pkg::STEP_W-1:0] step;
    logic [fsrv_pkg::VOL_W-1:0] vol_left;
    logic [fsrv_pkg::VOL_W-1:0] vol_right;
    logic [fsrv_pkg::PAN_W-1:0] pan;
    logic byte_mode;
    logic [fsrv_pkg::FRAC_WIDTH-1:0] phase_frac;
    logic [fsrv_pkg::SKIP_W-1:0] skips_left;
    mix_word_t owed_words[$];
    int mismatches;

    function new();
      step = fsrv_pkg::STEP_RESET;
      vol_left = fsrv_pkg::VOL_RESET;
      vol_right = fsrv_pkg::VOL_RESET;
      pan = fsrv_pkg::PAN_LEFT;
      byte_mode = 1'b0;
      phase_frac = '0;
      skips_left = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [fsrv_pkg::CFG_IDX_W-1:0] idx,
                            logic [fsrv_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        fsrv_pkg::CFG_STEP: step = data[fsrv_pkg::STEP_W-1:0];
        fsrv_pkg::CFG_LEFT: vol_left = data[fsrv_pkg::VOL_W-1:0];
        fsrv_pkg::CFG_RIGHT: vol_right = data[fsrv_pkg::VOL_W-1:0];
        fsrv_pkg::CFG_PAN: pan = data[fsrv_pkg::PAN_W-1:0];
        fsrv_pkg::CFG_BYTE: byte_mode = data[0];
        default: ;
      endcase
    endfunction

    // Volume product; 16-bit samples are floored by the shift, then clamped to 19 bits.
    function logic signed [fsrv_pkg::OUT_W-1:0] apply_volume(
        logic signed [fsrv_pkg::SAMPLE_W-1:0] s, logic [fsrv_pkg::VOL_W-1:0] vol);
      longint p;
      p = longint'(s) * longint'(vol);
      if (!byte_mode) p = p >>> fsrv_pkg::VOL_SHIFT;
      if (p < OUT_LO) p = OUT_LO;
      if (p > OUT_HI) p = OUT_HI;
      return p[fsrv_pkg::OUT_W-1:0];
    endfunction

    // Works out the output words that one accepted sample word causes.
    function void note_word(logic [fsrv_pkg::SAMPLE_W-1:0] raw);
      logic signed [fsrv_pkg::SAMPLE_W-1:0] s;
      mix_word_t w;
      logic [31:0] acc;
      logic [31:0] adv;
      int n;
      if (skips_left != 0) begin
        skips_left = skips_left - 1'b1;
        return;
      end
      if (byte_mode) begin
        s = {{(fsrv_pkg::SAMPLE_W - fsrv_pkg::BYTE_W){raw[fsrv_pkg::BYTE_W-1]}},
             raw[fsrv_pkg::BYTE_W-1:0]};
      end else begin
        s = raw;
      end
      w.left = (pan != fsrv_pkg::PAN_RIGHT) ? apply_volume(s, vol_left) : '0;
      w.right = (pan != fsrv_pkg::PAN_LEFT) ? apply_volume(s, vol_right) : '0;
      w.last = 1'b0;
      acc = 32'(phase_frac);
      n = 0;
      // Repeat the held sample until the phase carries or the cap is hit.
      while (n < fsrv_pkg::MAX_REPEAT) begin
        n++;
        acc = acc + 32'(step);
        adv = acc >> fsrv_pkg::FRAC_WIDTH;
        acc = acc & ((32'd1 << fsrv_pkg::FRAC_WIDTH) - 1);
        if (adv != 0) begin
          skips_left = (adv - 1 > fsrv_pkg::SKIP_MAX) ?
                       fsrv_pkg::SKIP_W'(fsrv_pkg::SKIP_MAX) : fsrv_pkg::SKIP_W'(adv - 1);
          break;
        end
      end
      phase_frac = acc[fsrv_pkg::FRAC_WIDTH-1:0];
      repeat (n - 1) owed_words.push_back(w);
      w.last = 1'b1;
      owed_words.push_back(w);
    endfunction

    function void check_word(mix_word_t got);
      mix_word_t want;
      if (owed_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word: left %0d right %0d last %0b",
                   got.left, got.right, got.last);
        return;
      end
      want = owed_words.pop_front();
      if (got.left !== want.left || got.right !== want.right || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output mismatch: expected left %0d right %0d last %0b, %s %0d %s %0d %s %0b",
                   want.left, want.right, want.last, "got left", got.left,
                   "right", got.right, "last", got.last);
      end
    endfunction

    function int pending();
      return owed_words.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [fsrv_pkg::SAMPLE_W-1:0] in_sample;
  logic out_valid;
  logic out_stall;
  logic signed [fsrv_pkg::OUT_W-1:0] out_left_sample;
  logic signed [fsrv_pkg::OUT_W-1:0] out_right_sample;
  logic out_last_of_run;
  logic cfg_we;
  logic [fsrv_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fsrv_pkg::CFG_DATA_W-1:0] cfg_data;

  resample_scoreboard sb = new();
  int src_idle_pct;
  int sink_idle_pct;
  logic hold_request;

  fixed_step_resampler_volume dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_left_sample(out_left_sample),
    .out_right_sample(out_right_sample),
    .out_last_of_run(out_last_of_run),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // Output side: check words at the rising edge, pick the stall at the falling edge.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_word('{left: out_left_sample, right: out_right_sample,
                        last: out_last_of_run});
      end
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < sink_idle_pct);
      end
    end
  end

  // Offers one sample word and returns at the falling edge after it was taken.
  task automatic send_word(logic [fsrv_pkg::SAMPLE_W-1:0] s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    sb.note_word(s);
    @(negedge clk);
  endtask

  task automatic program_reg(logic [fsrv_pkg::CFG_IDX_W-1:0] idx,
                             logic [fsrv_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drops the input valid, waits for every owed word, then lets a dropped word finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Puts random bits above a register's width half of the time; the block must ignore them.
  function automatic logic [fsrv_pkg::CFG_DATA_W-1:0] pad_noise(
      logic [fsrv_pkg::CFG_DATA_W-1:0] v, int w);
    logic [fsrv_pkg::CFG_DATA_W-1:0] n;
    n = fsrv_pkg::CFG_DATA_W'($urandom);
    return ($urandom_range(1) == 1) ? ((n << w) | v) : v;
  endfunction

  function automatic logic [fsrv_pkg::VOL_W-1:0] pick_volume();
    case ($urandom_range(5))
      0: return '0;
      1: return fsrv_pkg::VOL_RESET;
      2: return VOL_MAX;
      3: return '1;
      default: return fsrv_pkg::VOL_W'($urandom_range(4095));
    endcase
  endfunction

  function automatic logic [fsrv_pkg::STEP_W-1:0] pick_step();
    case ($urandom_range(9))
      0: return STEP_MIN;
      1: return STEP_MAX;
      2: return '1;
      3: return fsrv_pkg::STEP_W'($urandom_range(4095));
      4, 5: return fsrv_pkg::STEP_W'($urandom_range(1048575, 131073));
      default: return fsrv_pkg::STEP_W'($urandom_range(131072, 4096));
    endcase
  endfunction

  function automatic logic [fsrv_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return fsrv_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic configure_random();
    program_reg(fsrv_pkg::CFG_STEP, pick_step());
    program_reg(fsrv_pkg::CFG_LEFT,
                pad_noise(fsrv_pkg::CFG_DATA_W'(pick_volume()), fsrv_pkg::VOL_W));
    program_reg(fsrv_pkg::CFG_RIGHT,
                pad_noise(fsrv_pkg::CFG_DATA_W'(pick_volume()), fsrv_pkg::VOL_W));
    program_reg(fsrv_pkg::CFG_PAN,
                pad_noise(fsrv_pkg::CFG_DATA_W'($urandom_range(3)), fsrv_pkg::PAN_W));
    program_reg(fsrv_pkg::CFG_BYTE,
                pad_noise(fsrv_pkg::CFG_DATA_W'($urandom_range(1)), 1));
  endtask

  // Stimulus: directed settings first, then random phases.
  initial begin
    int sent;
    int phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    cfg_we = 1'b0;
    cfg_index = fsrv_pkg::CFG_STEP;
    cfg_data = '0;
    hold_request = 1'b0;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: equal-rate copy to the left side.
    send_word(16'h7FFF);
    send_word(16'h8000);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h0001);
    wait_idle();

    // Minimum step: sixteen repeats that end exactly on the carry.
    program_reg(fsrv_pkg::CFG_STEP, STEP_MIN);
    program_reg(fsrv_pkg::CFG_PAN, fsrv_pkg::CFG_DATA_W'(fsrv_pkg::PAN_BOTH));
    program_reg(fsrv_pkg::CFG_LEFT, fsrv_pkg::CFG_DATA_W'(VOL_MAX));
    program_reg(fsrv_pkg::CFG_RIGHT, '0);
    send_word(16'h7FFF);
    send_word(16'h8000);
    wait_idle();

    // Zero step hits the repeat cap; a large right volume saturates.
    program_reg(fsrv_pkg::CFG_STEP, '0);
    program_reg(fsrv_pkg::CFG_PAN, fsrv_pkg::CFG_DATA_W'(fsrv_pkg::PAN_RIGHT));
    program_reg(fsrv_pkg::CFG_RIGHT, '1);
    send_word(16'h7FFF);
    send_word(16'h8000);
    send_word(16'h0064);
    wait_idle();

    // Byte samples on the spare pan code; writes to spare indexes do nothing.
    program_reg(fsrv_pkg::CFG_STEP, fsrv_pkg::STEP_RESET);
    program_reg(fsrv_pkg::CFG_PAN, fsrv_pkg::CFG_DATA_W'(PAN_SPARE));
    program_reg(fsrv_pkg::CFG_BYTE, fsrv_pkg::CFG_DATA_W'(1));
    program_reg(fsrv_pkg::CFG_LEFT, '1);
    program_reg(fsrv_pkg::CFG_RIGHT, fsrv_pkg::CFG_DATA_W'(1));
    program_reg(CFG_SPARE_LO, '1);
    program_reg(CFG_SPARE_HI, '0);
    send_word(16'hFF80);
    send_word(16'h017F);
    send_word(16'h0080);
    wait_idle();

    // Maximum step drops the following words through the skip counter.
    program_reg(fsrv_pkg::CFG_STEP, STEP_MAX);
    send_word(16'hFF00);
    send_word(16'h1234);
    send_word(16'h5678);
    send_word(16'hA5A5);
    wait_idle();

    // Random phases: receiver-heavy idling, then sender-heavy, then none.
    sent = 0;
    phase = 0;
    while (sent < 200) begin
      wait_idle();
      configure_random();
      if (phase < 3) begin
        src_idle_pct = 17;
        sink_idle_pct = 85;
      end else if (phase < 6) begin
        src_idle_pct = 85;
        sink_idle_pct = 17;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      for (int i = 0; i < 25; i++) begin
        // One long receiver hold-off while words keep coming.
        if (phase == 1 && i == 5) hold_request = 1'b1;
        send_word(pick_sample());
        sent++;
      end
      phase++;
    end
    wait_idle();

    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
